FILE: design/kvpl_pkg.sv
// ----------------------------------------------------------------------------
// kvpl_pkg: shared types and constants of the paged KV cache
// Item and result structs, mode codes, controller states and the command and
// status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kvpl_pkg;

  localparam int MAX_SEQS_DEF  = 16;
  localparam int MAX_PAGES_DEF = 64;

  localparam int CFG_W   = 17;
  localparam int CNT_W   = 20;
  localparam int SUM_W   = 32;
  localparam int PROD_W  = 2 * CNT_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CW  = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] PAGE_SIZE_RESET = CFG_W'(4096);

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_WINDOW = 2'd1;
  localparam logic [1:0] MODE_EVICT  = 2'd2;

  function automatic int clog2_min1(input int v);
    return (v <= 2) ? 1 : $clog2(v);
  endfunction

  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0]       seq;
    logic [CNT_W-1:0] byte_count;
    logic [CNT_W-1:0] token_count;
    logic [SUM_W-1:0] token_target;
    logic [SUM_W-1:0] byte_target;
  } kvpl_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] window_tokens;
    logic [SUM_W-1:0] freed_bytes;
    logic             page_overflow;
  } kvpl_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_LOADN,
    S_A_CHK, S_A_CHK2, S_A_OPEN, S_A_FILL, S_A_CALC, S_A_MUL,
    S_A_DIV, S_A_DIVW, S_A_TOK, S_A_TAIL, S_A_TADD,
    S_W_CHK, S_W_RD, S_W_USE,
    S_E_CHK, S_E_POP, S_E_RD, S_E_USE,
    S_DONE
  } kvpl_state_t;

  typedef struct packed {
    logic latch;
    logic load_np;
    logic open_pg;
    logic set_ovf;
    logic calc_can;
    logic fill_wr;
    logic div_start;
    logic tok_upd;
    logic tail_add;
    logic w_step;
    logic w_use;
    logic e_pop;
    logic ev_sel;
    logic e_use;
    logic load_out;
  } kvpl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       seq_ok;
    logic       np_zero;
    logic       np_full;
    logic       fill_over;
    logic       bytes_zero;
    logic       bytes_left;
    logic       cnt_zero;
    logic       win_met;
    logic       lru_empty;
    logic       evict_met;
    logic       div_done;
    logic       out_busy;
  } kvpl_sts_t;

endpackage

`default_nettype wire

FILE: design/kv_page_pager_lru.sv
// ----------------------------------------------------------------------------
// kv_page_pager_lru: paged KV cache with least-recently-pinned eviction
// Per-sequence page lists with fill, token count and pin mark, plus an LRU
// ring of pinned pages; one result item per input item.
// ----------------------------------------------------------------------------
// One item is handled at a time and always yields exactly one result item.
// Append steps through each page it touches and is dominated by the
// bit-serial divider that shares tokens among pages. Window walks pages
// with registered page memory reads. Evict pops LRU entries (ring read,
// then page read). in_stall is high from acceptance until the result is
// loaded into the output register; the result register frees the input side
// while a result waits on out_stall. The page size register is written
// through the cfg port; the user must write it only while the block is idle,
// as the block itself does not enforce this; cfg_ready is always high. A page
// size of zero acts as one byte. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_page_pager_lru #(
  parameter int MAX_SEQS  = kvpl_pkg::MAX_SEQS_DEF,
  parameter int MAX_PAGES = kvpl_pkg::MAX_PAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire kvpl_pkg::kvpl_in_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output kvpl_pkg::kvpl_out_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [kvpl_pkg::CFG_W-1:0] cfg_data
);

  kvpl_pkg::kvpl_cmd_t cmd;
  kvpl_pkg::kvpl_sts_t sts;

  // take configuration writes every cycle
  assign cfg_ready = 1'b1;

  kvpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kvpl_dp #(
    .MAX_SEQS  (MAX_SEQS),
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: design/kvpl_div.sv
// ----------------------------------------------------------------------------
// kvpl_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient known to fit CNT_W.
// ----------------------------------------------------------------------------
`default_nettype none

module kvpl_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [kvpl_pkg::PROD_W-1:0] dividend,
  input  wire logic [kvpl_pkg::CNT_W-1:0]  divisor,
  output logic                             done,
  output logic [kvpl_pkg::CNT_W-1:0]       quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [kvpl_pkg::DIV_CW-1:0]  cnt_r;
  logic [kvpl_pkg::PROD_W-1:0]  quo_r;
  logic [kvpl_pkg::CNT_W-1:0]   rem_r;
  logic [kvpl_pkg::CNT_W:0]     rem_sh;
  logic                         take;

  assign rem_sh = {rem_r, quo_r[kvpl_pkg::PROD_W-1]};
  assign take   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= kvpl_pkg::DIV_CW'(kvpl_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - kvpl_pkg::DIV_CW'(1);
        if (cnt_r == kvpl_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[kvpl_pkg::PROD_W-2:0], take};
      rem_r <= take ? kvpl_pkg::CNT_W'(rem_sh - {1'b0, divisor})
                    : kvpl_pkg::CNT_W'(rem_sh);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[kvpl_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

FILE: design/kvpl_dp.sv
// ----------------------------------------------------------------------------
// kvpl_dp: datapath of the paged KV cache
// Page memories, per-sequence page counts, LRU ring, work registers, result
// register and the page size register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvpl_dp #(
  parameter int MAX_SEQS  = kvpl_pkg::MAX_SEQS_DEF,
  parameter int MAX_PAGES = kvpl_pkg::MAX_PAGES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kvpl_pkg::kvpl_in_t         in_data,
  input  wire logic                       cfg_we,
  input  wire logic [kvpl_pkg::CFG_W-1:0] cfg_data,
  input  wire kvpl_pkg::kvpl_cmd_t        cmd,
  output kvpl_pkg::kvpl_sts_t             sts,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output kvpl_pkg::kvpl_out_t             out_data
);

  localparam int TOTAL  = MAX_SEQS * MAX_PAGES;
  localparam int PA_W   = kvpl_pkg::clog2_min1(TOTAL);
  localparam int PIDX_W = kvpl_pkg::clog2_min1(MAX_PAGES);
  localparam int PC_W   = kvpl_pkg::clog2_min1(MAX_PAGES + 1);
  localparam int SEQ_W  = kvpl_pkg::clog2_min1(MAX_SEQS);
  localparam int LL_W   = kvpl_pkg::clog2_min1(TOTAL + 1);
  localparam int CW     = kvpl_pkg::CFG_W;
  localparam int NW     = kvpl_pkg::CNT_W;
  localparam int SW     = kvpl_pkg::SUM_W;

  // memories
  logic [CW-1:0]   fill_mem [TOTAL];
  logic [SW-1:0]   tok_mem  [TOTAL];
  logic            pin_mem  [TOTAL];
  logic [PA_W-1:0] lru_mem  [TOTAL];
  logic [PC_W-1:0] pis_mem  [MAX_SEQS];
  logic [MAX_SEQS-1:0] pis_vld_r;

  logic [CW-1:0]   fill_rd;
  logic [SW-1:0]   tok_rd;
  logic            pin_rd;
  logic [PA_W-1:0] lru_rd;
  logic [PC_W-1:0] pis_rd;

  // registers
  kvpl_pkg::kvpl_in_t item_r;
  kvpl_pkg::kvpl_out_t out_r;
  logic            out_valid_r;
  logic [CW-1:0]   cfg_r;
  logic [PC_W-1:0] npages_r;
  logic [PC_W-1:0] cnt_r;
  logic [PIDX_W-1:0] pidx_r;
  logic [NW-1:0]   bytes_r;
  logic [NW-1:0]   toks_r;
  logic [NW-1:0]   can_r;
  logic [kvpl_pkg::PROD_W-1:0] prod_r;
  logic [SW-1:0]   win_r;
  logic [SW-1:0]   freed_r;
  logic            ovf_r;
  logic [PA_W-1:0] ev_addr_r;
  logic [PA_W-1:0] front_r;
  logic [PA_W-1:0] back_r;
  logic [LL_W-1:0] len_r;

  logic [8:0]      seq_ext;
  logic [SEQ_W-1:0] seq_idx;
  logic [PA_W-1:0] base;
  logic [PA_W-1:0] pg_addr;
  logic [PA_W-1:0] open_addr;
  logic [PA_W-1:0] wr_addr;
  logic [PA_W-1:0] front_dec;
  logic [PA_W-1:0] back_dec;
  logic [CW-1:0]   cap;
  logic [CW-1:0]   room;
  logic [NW-1:0]   can_nxt;
  logic [NW:0]     fill_sum;
  logic [SW:0]     tok_sum;
  logic [SW:0]     tail_sum;
  logic [SW:0]     acc_sum;
  logic [SW:0]     fr_sum;
  logic [NW-1:0]   div_q;
  logic            div_done;
  logic            push;
  logic            fill_we;
  logic            tok_we;
  logic            pin_we;
  logic [CW-1:0]   fill_wd;
  logic [SW-1:0]   tok_wd;

  assign seq_ext   = {5'b0, item_r.seq};
  assign seq_idx   = seq_ext[SEQ_W-1:0];
  assign base      = PA_W'(seq_idx) * PA_W'(MAX_PAGES);
  assign pg_addr   = cmd.ev_sel ? ev_addr_r : base + PA_W'(pidx_r);
  assign open_addr = base + PA_W'(npages_r);
  assign wr_addr   = cmd.open_pg ? open_addr : pg_addr;
  assign front_dec = (front_r == '0) ? PA_W'(TOTAL - 1) : front_r - PA_W'(1);
  assign back_dec  = (back_r == '0) ? PA_W'(TOTAL - 1) : back_r - PA_W'(1);

  assign cap      = (cfg_r == '0) ? CW'(1) : cfg_r;
  assign fill_sum = (NW+1)'(fill_rd) + (NW+1)'(bytes_r);
  assign room     = (fill_rd >= cap) ? '0 : cap - fill_rd;
  assign can_nxt  = (NW'(room) < bytes_r) ? NW'(room) : bytes_r;
  assign tok_sum  = (SW+1)'(tok_rd) + (SW+1)'(div_q);
  assign tail_sum = (SW+1)'(tok_rd) + (SW+1)'(toks_r);
  assign acc_sum  = (SW+1)'(win_r) + (SW+1)'(tok_rd);
  assign fr_sum   = (SW+1)'(freed_r) + (SW+1)'(fill_rd);

  assign push    = cmd.w_use && !pin_rd && (len_r < LL_W'(TOTAL));
  assign fill_we = cmd.open_pg || cmd.fill_wr;
  assign fill_wd = cmd.open_pg ? '0 : fill_rd + CW'(can_r);
  assign tok_we  = cmd.open_pg || cmd.tok_upd || cmd.tail_add;
  always_comb begin
    if (cmd.open_pg) begin
      tok_wd = '0;
    end else if (cmd.tok_upd) begin
      tok_wd = tok_sum[SW] ? '1 : tok_sum[SW-1:0];
    end else begin
      tok_wd = tail_sum[SW] ? '1 : tail_sum[SW-1:0];
    end
  end
  assign pin_we = cmd.open_pg || (cmd.w_use && !pin_rd) || (cmd.e_use && pin_rd);

  kvpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (bytes_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // page memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[wr_addr] <= fill_wd;
    end
    fill_rd <= fill_mem[pg_addr];
  end

  always_ff @(posedge clk) begin
    if (tok_we) begin
      tok_mem[wr_addr] <= tok_wd;
    end
    tok_rd <= tok_mem[pg_addr];
  end

  always_ff @(posedge clk) begin
    if (pin_we) begin
      pin_mem[wr_addr] <= cmd.w_use;
    end
    pin_rd <= pin_mem[pg_addr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      lru_mem[front_dec] <= pg_addr;
    end
    lru_rd <= lru_mem[back_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.open_pg) begin
      pis_mem[seq_idx] <= npages_r + PC_W'(1);
    end
    pis_rd <= pis_vld_r[seq_idx] ? pis_mem[seq_idx] : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pis_vld_r   <= '0;
      front_r     <= '0;
      back_r      <= '0;
      len_r       <= '0;
      cfg_r       <= kvpl_pkg::PAGE_SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.open_pg) begin
        pis_vld_r[seq_idx] <= 1'b1;
      end
      if (push) begin
        front_r <= front_dec;
        if (len_r == '0) begin
          back_r <= front_dec;
        end
        len_r <= len_r + LL_W'(1);
      end else if (cmd.e_pop) begin
        back_r <= back_dec;
        len_r  <= len_r - LL_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r  <= in_data;
      bytes_r <= in_data.byte_count;
      toks_r  <= in_data.token_count;
      win_r   <= '0;
      freed_r <= '0;
      ovf_r   <= 1'b0;
    end
    if (cmd.load_np) begin
      npages_r <= pis_rd;
      cnt_r    <= pis_rd;
      pidx_r   <= PIDX_W'(pis_rd - PC_W'(1));
    end
    if (cmd.open_pg) begin
      npages_r <= npages_r + PC_W'(1);
      pidx_r   <= PIDX_W'(npages_r);
    end
    if (cmd.set_ovf) begin
      ovf_r <= 1'b1;
    end
    if (cmd.calc_can) begin
      can_r <= can_nxt;
    end
    if (cmd.fill_wr) begin
      prod_r <= kvpl_pkg::PROD_W'(toks_r) * kvpl_pkg::PROD_W'(can_r);
    end
    if (cmd.tok_upd) begin
      bytes_r <= bytes_r - can_r;
      toks_r  <= toks_r - div_q;
    end
    if (cmd.w_step) begin
      cnt_r  <= cnt_r - PC_W'(1);
      pidx_r <= PIDX_W'(cnt_r - PC_W'(1));
    end
    if (cmd.w_use) begin
      win_r <= acc_sum[SW] ? '1 : acc_sum[SW-1:0];
    end
    if (cmd.e_pop) begin
      ev_addr_r <= lru_rd;
    end
    if (cmd.e_use && pin_rd) begin
      freed_r <= fr_sum[SW] ? '1 : fr_sum[SW-1:0];
    end
    if (cmd.load_out) begin
      out_r.window_tokens <= win_r;
      out_r.freed_bytes   <= freed_r;
      out_r.page_overflow <= ovf_r;
    end
  end

  always_comb begin
    sts.mode       = item_r.mode;
    sts.seq_ok     = seq_ext < 9'(MAX_SEQS);
    sts.np_zero    = npages_r == '0;
    sts.np_full    = npages_r >= PC_W'(MAX_PAGES);
    sts.fill_over  = fill_sum > (NW+1)'(cap);
    sts.bytes_zero = bytes_r == '0;
    sts.bytes_left = bytes_r != can_r;
    sts.cnt_zero   = cnt_r == '0;
    sts.win_met    = win_r >= item_r.token_target;
    sts.lru_empty  = len_r == '0;
    sts.evict_met  = freed_r >= item_r.byte_target;
    sts.div_done   = div_done;
    sts.out_busy   = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: design/kvpl_ctrl.sv
// ----------------------------------------------------------------------------
// kvpl_ctrl: controller of the paged KV cache
// Sequences append, window and evict as steps over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module kvpl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire kvpl_pkg::kvpl_sts_t  sts,
  output kvpl_pkg::kvpl_cmd_t       cmd
);

  kvpl_pkg::kvpl_state_t state_r;
  kvpl_pkg::kvpl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kvpl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kvpl_pkg::S_IDLE:   if (in_valid) state_nxt = kvpl_pkg::S_START;
      kvpl_pkg::S_START:  state_nxt = kvpl_pkg::S_LOADN;
      kvpl_pkg::S_LOADN: begin
        if (sts.mode == kvpl_pkg::MODE_APPEND && sts.seq_ok) begin
          state_nxt = kvpl_pkg::S_A_CHK;
        end else if (sts.mode == kvpl_pkg::MODE_WINDOW && sts.seq_ok) begin
          state_nxt = kvpl_pkg::S_W_CHK;
        end else if (sts.mode == kvpl_pkg::MODE_EVICT) begin
          state_nxt = kvpl_pkg::S_E_CHK;
        end else begin
          state_nxt = kvpl_pkg::S_DONE;
        end
      end
      kvpl_pkg::S_A_CHK:
        state_nxt = sts.np_zero ? kvpl_pkg::S_A_OPEN : kvpl_pkg::S_A_CHK2;
      kvpl_pkg::S_A_CHK2:
        state_nxt = sts.fill_over ? kvpl_pkg::S_A_OPEN : kvpl_pkg::S_A_FILL;
      kvpl_pkg::S_A_OPEN: begin
        if (!sts.np_full) begin
          state_nxt = kvpl_pkg::S_A_FILL;
        end else if (sts.np_zero) begin
          state_nxt = kvpl_pkg::S_DONE;
        end else begin
          state_nxt = kvpl_pkg::S_A_TAIL;
        end
      end
      kvpl_pkg::S_A_FILL:
        state_nxt = sts.bytes_zero ? kvpl_pkg::S_A_TAIL : kvpl_pkg::S_A_CALC;
      kvpl_pkg::S_A_CALC: state_nxt = kvpl_pkg::S_A_MUL;
      kvpl_pkg::S_A_MUL:  state_nxt = kvpl_pkg::S_A_DIV;
      kvpl_pkg::S_A_DIV:  state_nxt = kvpl_pkg::S_A_DIVW;
      kvpl_pkg::S_A_DIVW: if (sts.div_done) state_nxt = kvpl_pkg::S_A_TOK;
      kvpl_pkg::S_A_TOK:
        state_nxt = sts.bytes_left ? kvpl_pkg::S_A_OPEN : kvpl_pkg::S_A_TAIL;
      kvpl_pkg::S_A_TAIL: state_nxt = kvpl_pkg::S_A_TADD;
      kvpl_pkg::S_A_TADD: state_nxt = kvpl_pkg::S_DONE;
      kvpl_pkg::S_W_CHK:
        state_nxt = (sts.cnt_zero || sts.win_met) ? kvpl_pkg::S_DONE : kvpl_pkg::S_W_RD;
      kvpl_pkg::S_W_RD:   state_nxt = kvpl_pkg::S_W_USE;
      kvpl_pkg::S_W_USE:  state_nxt = kvpl_pkg::S_W_CHK;
      kvpl_pkg::S_E_CHK:
        state_nxt = (sts.lru_empty || sts.evict_met) ? kvpl_pkg::S_DONE
                                                     : kvpl_pkg::S_E_POP;
      kvpl_pkg::S_E_POP:  state_nxt = kvpl_pkg::S_E_RD;
      kvpl_pkg::S_E_RD:   state_nxt = kvpl_pkg::S_E_USE;
      kvpl_pkg::S_E_USE:  state_nxt = kvpl_pkg::S_E_CHK;
      kvpl_pkg::S_DONE:   if (!sts.out_busy) state_nxt = kvpl_pkg::S_IDLE;
      default:            state_nxt = kvpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      kvpl_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      kvpl_pkg::S_LOADN:  cmd.load_np = 1'b1;
      kvpl_pkg::S_A_OPEN: begin
        cmd.open_pg = !sts.np_full;
        cmd.set_ovf = sts.np_full;
      end
      kvpl_pkg::S_A_CALC: cmd.calc_can  = 1'b1;
      kvpl_pkg::S_A_MUL:  cmd.fill_wr   = 1'b1;
      kvpl_pkg::S_A_DIV:  cmd.div_start = 1'b1;
      kvpl_pkg::S_A_TOK:  cmd.tok_upd   = 1'b1;
      kvpl_pkg::S_A_TADD: cmd.tail_add  = 1'b1;
      kvpl_pkg::S_W_CHK:  cmd.w_step    = !(sts.cnt_zero || sts.win_met);
      kvpl_pkg::S_W_USE:  cmd.w_use     = 1'b1;
      kvpl_pkg::S_E_POP:  cmd.e_pop     = 1'b1;
      kvpl_pkg::S_E_RD:   cmd.ev_sel    = 1'b1;
      kvpl_pkg::S_E_USE: begin
        cmd.ev_sel = 1'b1;
        cmd.e_use  = 1'b1;
      end
      kvpl_pkg::S_DONE:   cmd.load_out  = !sts.out_busy;
      default:            cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: dv/kv_page_pager_lru_tb.sv
// ----------------------------------------------------------------------------
// kv_page_pager_lru_tb: self-checking bench for the paged KV cache
// Drives append, window and evict items through the valid/stall handshake,
// predicts every result item from a local model of the page lists and LRU
// ring, and compares results in order under several page sizes and idling.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_page_pager_lru_tb;

  localparam int NSEQ  = 16;
  localparam int NPAGE = 64;
  localparam int NTOT  = NSEQ * NPAGE;
  localparam logic [1:0] MODE_NONE = 2'd3;  // undefined mode, answers zeros
  localparam int unsigned SAT = 32'hFFFF_FFFF;
  localparam int LIMIT = 40000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  kvpl_pkg::kvpl_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kvpl_pkg::kvpl_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [kvpl_pkg::CFG_W-1:0] cfg_data = '0;

  kv_page_pager_lru dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Local copy of the cache state; only written entries are ever read.
  int unsigned pg_fill[NTOT];
  int unsigned pg_tok[NTOT];
  bit          pg_pin[NTOT];
  int unsigned seq_pages[NSEQ];
  int unsigned ring[NTOT];
  int unsigned ring_front = 0, ring_back = 0, ring_len = 0;
  logic [kvpl_pkg::CFG_W-1:0] psize = kvpl_pkg::PAGE_SIZE_RESET;

  function automatic int unsigned sat_add(int unsigned a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > SAT) ? SAT : int'(s);
  endfunction

  function automatic bit page_open(int unsigned s);
    int unsigned p;
    if (seq_pages[s] >= NPAGE) return 1'b0;
    p = s * NPAGE + seq_pages[s];
    pg_fill[p] = 0;
    pg_tok[p]  = 0;
    pg_pin[p]  = 1'b0;
    seq_pages[s]++;
    return 1'b1;
  endfunction

  function automatic bit append_pages(int unsigned s, longint unsigned bytes,
                                      longint unsigned toks);
    longint unsigned cap, fill, room, can, tc;
    int unsigned last;
    bit ovf;
    cap = (psize == 0) ? 1 : psize;
    ovf = 1'b0;
    // open a page when the bytes do not fit whole in the newest one
    if (seq_pages[s] == 0 ||
        longint'(pg_fill[s * NPAGE + seq_pages[s] - 1]) + bytes > cap) begin
      if (!page_open(s)) ovf = 1'b1;
    end
    if (seq_pages[s] == 0) return ovf;
    while (bytes > 0 && !ovf) begin
      last = s * NPAGE + seq_pages[s] - 1;
      fill = pg_fill[last];
      room = (fill >= cap) ? 0 : cap - fill;
      can  = (room < bytes) ? room : bytes;
      pg_fill[last] = int'(fill + can);
      tc = toks * can / bytes;
      pg_tok[last] = sat_add(pg_tok[last], tc);
      bytes -= can;
      toks  -= tc;
      if (bytes > 0 && !page_open(s)) ovf = 1'b1;
    end
    // rounding remainder and dropped tokens land on the newest page
    last = s * NPAGE + seq_pages[s] - 1;
    pg_tok[last] = sat_add(pg_tok[last], toks);
    return ovf;
  endfunction

  function automatic int unsigned window_walk(int unsigned s, int unsigned target);
    int unsigned acc, i, p;
    acc = 0;
    i = seq_pages[s];
    while (i > 0 && acc < target) begin
      i--;
      p = s * NPAGE + i;
      if (!pg_pin[p]) begin
        pg_pin[p] = 1'b1;
        if (ring_len < NTOT) begin
          ring_front = (ring_front == 0) ? NTOT - 1 : ring_front - 1;
          ring[ring_front] = p;
          if (ring_len == 0) ring_back = ring_front;
          ring_len++;
        end
      end
      acc = sat_add(acc, pg_tok[p]);
    end
    return acc;
  endfunction

  function automatic int unsigned unpin_oldest(int unsigned target);
    int unsigned freed, p;
    freed = 0;
    while (ring_len > 0 && freed < target) begin
      p = ring[ring_back];
      ring_back = (ring_back == 0) ? NTOT - 1 : ring_back - 1;
      ring_len--;
      if (p < NTOT && pg_pin[p]) begin
        pg_pin[p] = 1'b0;
        freed = sat_add(freed, pg_fill[p]);
      end
    end
    return freed;
  endfunction

  function automatic kvpl_pkg::kvpl_out_t predict_result(kvpl_pkg::kvpl_in_t it);
    kvpl_pkg::kvpl_out_t r;
    r = '0;
    case (it.mode)
      kvpl_pkg::MODE_APPEND:
        r.page_overflow = append_pages(it.seq, it.byte_count, it.token_count);
      kvpl_pkg::MODE_WINDOW: r.window_tokens = window_walk(it.seq, it.token_target);
      kvpl_pkg::MODE_EVICT:  r.freed_bytes   = unpin_oldest(it.byte_target);
      default: ;
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------ bench state
  kvpl_pkg::kvpl_in_t  pending_items[$];
  kvpl_pkg::kvpl_out_t expected_results[$];
  int n_queued = 0;
  int n_accepted = 0;
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int cycles = 0;

  // Driver: hold a stalled item, otherwise offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_result(in_data));
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted result item.
  always @(posedge clk) begin
    kvpl_pkg::kvpl_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.window_tokens !== want.window_tokens) begin
            $error("window_tokens exp %0h got %0h", want.window_tokens,
                   out_data.window_tokens);
            errors++;
          end
          if (out_data.freed_bytes !== want.freed_bytes) begin
            $error("freed_bytes exp %0h got %0h", want.freed_bytes,
                   out_data.freed_bytes);
            errors++;
          end
          if (out_data.page_overflow !== want.page_overflow) begin
            $error("page_overflow exp %0b got %0b", want.page_overflow,
                   out_data.page_overflow);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic kvpl_pkg::kvpl_in_t mk(logic [1:0] m, int unsigned s,
                                            int unsigned b, int unsigned t,
                                            int unsigned tt, int unsigned bt);
    kvpl_pkg::kvpl_in_t it;
    it.mode = m;
    it.seq = s[3:0];
    it.byte_count = b[kvpl_pkg::CNT_W-1:0];
    it.token_count = t[kvpl_pkg::CNT_W-1:0];
    it.token_target = tt;
    it.byte_target = bt;
    return it;
  endfunction

  function automatic int unsigned rnd_target();
    case ($urandom_range(9))
      0: return 0;
      1: return SAT;
      2: return $urandom();
      default: return $urandom_range(4000);
    endcase
  endfunction

  // Mostly appends that fit in a couple of pages, with windows, evicts and undefined modes.
  function automatic kvpl_pkg::kvpl_in_t rnd_item();
    int unsigned r, cap, b;
    cap = (psize == 0) ? 1 : psize;
    r = $urandom_range(99);
    b = ($urandom_range(19) == 0) ? $urandom() : $urandom_range(0, 2 * cap);
    if (r < 50)
      return mk(kvpl_pkg::MODE_APPEND, $urandom_range(15), b, $urandom(), $urandom(),
                $urandom());
    else if (r < 80)
      return mk(kvpl_pkg::MODE_WINDOW, $urandom_range(15), $urandom(), $urandom(),
                rnd_target(), $urandom());
    else if (r < 95)
      return mk(kvpl_pkg::MODE_EVICT, $urandom_range(15), $urandom(), $urandom(),
                $urandom(),
                ($urandom_range(9) == 0) ? rnd_target() : $urandom_range(20000));
    else
      return mk(MODE_NONE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  task automatic queue_item(kvpl_pkg::kvpl_in_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Pause the sender until every result has come back, plus some slack.
  task automatic drain();
    do @(posedge clk); while (n_accepted != n_queued || expected_results.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  // Write the page size while the block is idle.
  task automatic write_page_size(logic [kvpl_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    psize = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  logic [kvpl_pkg::CFG_W-1:0] sizes[6];
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset page size
    queue_item(mk(kvpl_pkg::MODE_APPEND, 0, 0, 5, 0, 0));            // zero bytes opens a page
    queue_item(mk(kvpl_pkg::MODE_APPEND, 0, 4091, 20'hFFFFF, 0, 0)); // leaves five bytes of room
    queue_item(mk(kvpl_pkg::MODE_APPEND, 0, 1, 7, 0, 0));            // fits in the open page
    queue_item(mk(kvpl_pkg::MODE_APPEND, 0, 9000, 333, 0, 0));       // spans pages
    queue_item(mk(kvpl_pkg::MODE_APPEND, 1, 20'hFFFFF, 20'hFFFFF, 0, 0)); // out of slots
    queue_item(mk(kvpl_pkg::MODE_APPEND, 1, 10, 10, 0, 0));          // full sequence again
    queue_item(mk(kvpl_pkg::MODE_APPEND, 1, 0, 3, 0, 0));
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 15, 0, 0, 5, 0));           // empty sequence
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 0, 0, 0, 0, 0));            // zero target
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 0, 0, 0, 1, 0));
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 1, 0, 0, SAT, 0));          // walk every page
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 0, 0, 0, SAT, 0));
    queue_item(mk(MODE_NONE, 15, 20'hFFFFF, 20'hFFFFF, SAT, SAT));
    queue_item(mk(kvpl_pkg::MODE_EVICT, 0, 0, 0, 0, 0));
    queue_item(mk(kvpl_pkg::MODE_EVICT, 0, 0, 0, 0, 1));
    queue_item(mk(kvpl_pkg::MODE_EVICT, 0, 0, 0, 0, SAT));           // empties the queue
    queue_item(mk(kvpl_pkg::MODE_EVICT, 0, 0, 0, 0, SAT));           // empty queue
    queue_item(mk(kvpl_pkg::MODE_WINDOW, 1, 0, 0, SAT, 0));          // repin after evict
    snd_idle = 34;
    rcv_idle = 57;
    drain();

    // random phases: extremes of the page size, lowered sizes, random sizes
    sizes[0] = 17'd0;
    sizes[1] = 17'h10000;
    sizes[2] = 17'hFFFF;
    sizes[3] = 17'd16;
    sizes[4] = 17'($urandom_range(1, 8192));
    sizes[5] = 17'd1;
    for (int ph = 0; ph < 6; ph++) begin
      write_page_size(sizes[ph]);
      if (ph < 2) begin
        snd_idle = 34;
        rcv_idle = 57;
      end else if (ph < 4) begin
        snd_idle = 57;
        rcv_idle = 34;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      for (int i = 0; i < 285; i++) queue_item(rnd_item());
      drain();
    end

    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/kvpl_pkg.sv
design/kvpl_div.sv
design/kvpl_dp.sv
design/kvpl_ctrl.sv
design/kv_page_pager_lru.sv
dv/kv_page_pager_lru_tb.sv
